[hw/rtl/dsed_pkg.sv]
// Package with the shared types and constants of the DLE STX ETX deframer.
`default_nettype none

package dsed_pkg;

  // Control characters of the byte-stuffed line format.
  localparam logic [7:0] DLE_CODE = 8'h10;
  localparam logic [7:0] STX_CODE = 8'h02;
  localparam logic [7:0] ETX_CODE = 8'h03;

  // Frame buffer size and the width of byte indexes within a frame.
  localparam int unsigned MAX_FRAME = 120;
  localparam int unsigned CNT_W     = 7;
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(MAX_FRAME - 1);

  // Reset value of the idle limit register and of the idle counter.
  localparam logic [7:0] IDLE_LIMIT_RESET = 8'd30;

  // Input kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_IDLE = 1'b1;

  // Result event codes.
  localparam logic [1:0] EV_BYTE    = 2'd0;
  localparam logic [1:0] EV_END     = 2'd1;
  localparam logic [1:0] EV_ABORT   = 2'd2;
  localparam logic [1:0] EV_TIMEOUT = 2'd3;

  // Deframer state carried from one item to the next.
  typedef struct packed {
    logic             escape_pending;
    logic             frame_open;
    logic [CNT_W-1:0] byte_count;
    logic [7:0]       idle_count;
  } state_t;

  // One result item.
  typedef struct packed {
    logic [1:0]       event_res;
    logic [7:0]       payload;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] frame_length;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/dsed_decode.sv]
// Combinational per-item step: unescaping, framing and idle timeout.
`default_nettype none

module dsed_decode
  import dsed_pkg::*;
(
  input  wire state_t      state,
  input  wire logic        kind,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [7:0]  idle_limit,
  output state_t           state_next,
  output logic             res_valid,
  output result_t          res
);

  // A payload byte either goes out with its index or overflows the frame.
  logic    take_valid;
  logic    take_overflow;

  always_comb begin
    take_overflow = state.byte_count >= LAST_POS;
    take_valid    = state.frame_open;
  end

  always_comb begin
    state_next = state;
    res_valid  = 1'b0;
    res        = '0;

    if (kind == KIND_IDLE) begin
      // Idle tick: count down, report a timeout on expiry.
      if (state.idle_count <= 8'd1) begin
        state_next.escape_pending = 1'b0;
        state_next.frame_open     = 1'b0;
        state_next.byte_count     = '0;
        state_next.idle_count     = idle_limit;
        res_valid                 = 1'b1;
        res.event_res             = EV_TIMEOUT;
      end else begin
        state_next.idle_count = state.idle_count - 8'd1;
      end
    end else begin
      state_next.idle_count = idle_limit;
      if (!state.escape_pending && rx_byte == DLE_CODE) begin
        // Start of an escape sequence.
        state_next.escape_pending = 1'b1;
      end else if (!state.escape_pending || rx_byte == DLE_CODE) begin
        // Plain byte or escaped DLE: payload when a frame is open.
        state_next.escape_pending = 1'b0;
        if (take_valid) begin
          res_valid = 1'b1;
          if (take_overflow) begin
            state_next.frame_open = 1'b0;
            state_next.byte_count = '0;
            res.event_res         = EV_ABORT;
          end else begin
            state_next.byte_count = state.byte_count + 1'b1;
            res.event_res         = EV_BYTE;
            res.payload           = rx_byte;
            res.position          = state.byte_count;
          end
        end
      end else begin
        // Second byte of an escape other than DLE.
        state_next.escape_pending = 1'b0;
        if (rx_byte == STX_CODE) begin
          state_next.frame_open = 1'b1;
          state_next.byte_count = '0;
          if (state.frame_open) begin
            res_valid     = 1'b1;
            res.event_res = EV_ABORT;
          end
        end else if (state.frame_open) begin
          state_next.frame_open = 1'b0;
          state_next.byte_count = '0;
          res_valid             = 1'b1;
          if (rx_byte == ETX_CODE) begin
            res.event_res    = EV_END;
            res.frame_length = state.byte_count;
          end else begin
            res.event_res = EV_ABORT;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dle_stx_etx_deframer_core.sv]
// Top level of the DLE STX ETX deframer: state, output register and skid stage.
//
// Usage:
//   The input channel (in_valid, in_stall, kind, rx_byte) carries one received
//   byte (kind 0) or one idle tick (kind 1) per transaction. A transaction
//   takes place at a rising edge with in_valid high and in_stall low.
//   The output channel (out_valid, out_stall, event_res, payload, position,
//   frame_length) carries at most one result per input transaction: a payload
//   byte with its index, a frame end with its length, a frame abort, or an
//   idle timeout. Bytes outside a frame and idle ticks before expiry give none.
//   The cfg channel writes the idle limit; cfg_ready is always high, and the
//   new limit applies at the next reload of the idle counter.
//   A result is registered in the output register, or in the skid register
//   when the output register holds a result not yet taken. Throughput is one
//   item per cycle while in_stall is low; the state update is combinational.
//   When the receiver stalls, one further result goes into a skid register
//   and in_stall then rises until the skid register drains.
//   Reset (rst, synchronous) empties both registers, closes any frame, clears
//   a pending escape and loads 30 into both the idle limit and the counter.
`default_nettype none

module dle_stx_etx_deframer_core
  import dsed_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // Input channel.
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       kind,
  input  wire logic [7:0] rx_byte,
  // Output channel.
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      event_res,
  output logic [7:0]      payload,
  output logic [6:0]      position,
  output logic [6:0]      frame_length,
  // Configuration channel.
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  logic [7:0] idle_limit;
  state_t     state;
  state_t     state_next;
  logic       res_valid;
  result_t    res;
  logic       accept;
  logic       push;
  logic       pop;
  result_t    out_res;
  result_t    skid_res;
  logic       skid_valid;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !in_stall;
  assign push      = accept && res_valid;
  assign pop       = out_valid && !out_stall;

  // Per-item decode of the current state and input.
  dsed_decode u_decode (
    .state      (state),
    .kind       (kind),
    .rx_byte    (rx_byte),
    .idle_limit (idle_limit),
    .state_next (state_next),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Idle limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit <= IDLE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      idle_limit <= cfg_data;
    end
  end

  // Deframer state advances on every input transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.escape_pending <= 1'b0;
      state.frame_open     <= 1'b0;
      state.byte_count     <= '0;
      state.idle_count     <= IDLE_LIMIT_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload side of the output and skid registers.
  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else begin
        out_res <= res;
      end
    end else if (push) begin
      skid_res <= res;
    end
  end

  assign event_res    = out_res.event_res;
  assign payload      = out_res.payload;
  assign position     = out_res.position;
  assign frame_length = out_res.frame_length;

  // The skid register only fills while the output register holds a result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register is empty");

  // A closed frame always has a zero byte count.
  a_closed_count: assert property (@(posedge clk) disable iff (rst)
    !state.frame_open |-> state.byte_count == '0)
    else $error("byte count nonzero outside a frame");

  // The byte count never passes the last buffer position.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state.byte_count <= LAST_POS)
    else $error("byte count beyond frame buffer");

  // A reported payload byte always lies inside the buffer.
  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EV_BYTE |-> position < LAST_POS)
    else $error("payload byte reported at overflow position");

  // A timeout reloads the counter and closes the frame.
  a_timeout_clears: assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_IDLE && state.idle_count <= 8'd1
    |=> !state.frame_open && !state.escape_pending)
    else $error("frame state survived an idle timeout");

endmodule

`default_nettype wire
